// File: src/pn2d_pkg.sv
// ============================================================================
// pn2d_pkg
// Shared constants, types and the quarter-wave sine table for the 2D
// gradient noise evaluator.
// ============================================================================
package pn2d_pkg;

    // Fixed-point layout
    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = 23;
    localparam int INT_W      = COORD_W - FRAC_BITS;
    localparam int ANGLE_BITS = 10;
    localparam int ROM_N      = 1 << (ANGLE_BITS - 2);

    // Configuration register indexes
    localparam logic [1:0] REG_ORIGIN_X  = 2'd0;
    localparam logic [1:0] REG_ORIGIN_Y  = 2'd1;
    localparam logic [1:0] REG_GRID_STEP = 2'd2;
    localparam logic [1:0] REG_GRID_CELLS = 2'd3;

    // Hash multipliers
    localparam logic [31:0] HASH_M1 = 32'd3284157443;
    localparam logic [31:0] HASH_M2 = 32'd1911520717;
    localparam logic [31:0] HASH_M3 = 32'd2048419325;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

    typedef logic [0:ROM_N][15:0] sin_rom_t;

    // Quarter-wave sine, Q15: Taylor series to degree 9 in Q30, each step
    // truncated, then rounded half up to Q15 and capped at 1.0.
    function automatic sin_rom_t build_sin_rom();
        sin_rom_t rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        for (int k = 0; k <= ROM_N; k++) begin
            x  = (64'(k) * HALF_PI_Q30) >> (ANGLE_BITS - 2);
            x2 = (x * x) >> 30;
            t  = ONE_Q30 - x2 / 72;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
            s  = (x * t) >> 30;
            s  = (s + 64'd16384) >> 15;
            if (s > 64'd32768) begin
                s = 64'd32768;
            end
            rom[k] = s[15:0];
        end
        return rom;
    endfunction

    localparam sin_rom_t SIN_ROM = build_sin_rom();

endpackage

// File: src/perlin_noise_2d_evaluator.sv
// ============================================================================
// perlin_noise_2d_evaluator
// Hashed-gradient 2D noise: per point, four corner gradients from a
// multiply/rotate hash, dot products, quintic fade and bilinear blend.
// ============================================================================
//
//  channel   dir   transaction content
//  -------   ---   -------------------------------------------------------
//  s_axis    in    coord_x[22:0], coord_y[45:23]
//  m_axis    out   noise_value[15:0], gray_level[23:16], out_of_range[24]
//  cfg       in    cfg_wr_en / cfg_addr / cfg_wr_data, one register per write
//
//  One point per clock sustained while the output is empty or taken; the depth is
//  set by the three chained 32-bit hash multiplies and the dot/blend multiplier chain.
//  Reset (aresetn low, synchronous) clears the stage valid bits and the
//  configuration registers (origins 0, step 1, cells 1).
//  All stages advance together while the output is empty or taken; a stall
//  freezes the whole pipeline and s_axis_tready drops.
//
module perlin_noise_2d_evaluator
    import pn2d_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // coord_x, coord_y, zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // noise_value, gray_level, out_of_range, pad
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wr_data
);

    localparam int NSTG = 12;

    // configuration
    logic [31:0] origin_x_reg;
    logic [31:0] origin_y_reg;
    logic [15:0] grid_step_reg;
    logic [6:0]  grid_cells_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            grid_step_reg  <= 16'd1;
            grid_cells_reg <= 7'd1;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_ORIGIN_X:   origin_x_reg   <= cfg_wr_data;
                REG_ORIGIN_Y:   origin_y_reg   <= cfg_wr_data;
                REG_GRID_STEP:  grid_step_reg  <= cfg_wr_data[15:0];
                REG_GRID_CELLS: grid_cells_reg <= cfg_wr_data[6:0];
                default: ;
            endcase
        end
    end

    // global advance
    logic [NSTG:1] vld_reg;
    logic          en;

    assign en            = !vld_reg[NSTG] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[NSTG];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTG-1:1], s_axis_tvalid};
        end
    end

    // ---------------- stage 1: split point, lattice positions, fade step 1
    logic [COORD_W-1:0]   in_p [2];
    logic [INT_W-1:0]     in_i [2];
    logic [FRAC_BITS-1:0] in_f [2];
    logic [31:0]          pos_next [2][2];   // [axis][corner offset]
    logic [15:0]          t2_next [2];
    logic signed [20:0]   p_next [2];
    logic                 oor_next;

    always_comb begin
        in_p[0] = s_axis_tdata[COORD_W-1:0];
        in_p[1] = s_axis_tdata[2*COORD_W-1:COORD_W];
        for (int a = 0; a < 2; a++) begin
            logic [31:0] sq;
            in_i[a] = in_p[a][COORD_W-1:FRAC_BITS];
            in_f[a] = in_p[a][FRAC_BITS-1:0];
            sq = in_f[a] * in_f[a];
            t2_next[a] = sq[31:16];
            p_next[a]  = $signed({5'd0, in_f[a]}) * 21'sd6 - 21'sd983040;
        end
        for (int o = 0; o < 2; o++) begin
            logic [INT_W:0] cx;
            logic [INT_W:0] cy;
            logic [23:0]    mx;
            logic [23:0]    my;
            cx = {1'b0, in_i[0]} + (INT_W+1)'(o);
            cy = {1'b0, in_i[1]} + (INT_W+1)'(o);
            mx = cx * grid_step_reg;
            my = cy * grid_step_reg;
            pos_next[0][o] = origin_x_reg + {8'd0, mx};
            pos_next[1][o] = origin_y_reg + {8'd0, my};
        end
        oor_next = (in_i[0] > grid_cells_reg) || (in_i[1] > grid_cells_reg);
    end

    logic [31:0]          pos_reg [2][2];
    logic [15:0]          t2_reg [2];
    logic signed [20:0]   p_reg [2];
    logic [FRAC_BITS-1:0] fr_reg [1:5][2];   // fraction carried to the dots
    logic                 oor_reg [1:11];

    // ---------------- stage 2: first hash multiply, fade step 2
    logic [31:0]        am_next [2];
    logic [15:0]        t3_next [2];
    logic signed [20:0] q_next [2];

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            logic [31:0]        pr;
            logic signed [37:0] tp;
            am_next[a] = pos_reg[0][a] * HASH_M1;
            pr = t2_reg[a] * fr_reg[1][a];
            t3_next[a] = pr[31:16];
            tp = $signed({1'b0, fr_reg[1][a]}) * p_reg[a];
            q_next[a] = 21'(tp >>> 16) + 21'sd655360;
        end
    end

    logic [31:0]        am_reg [2];
    logic [31:0]        by_reg [2];
    logic [15:0]        t3_reg [2];
    logic signed [20:0] q_reg [2];

    // ---------------- stage 3: second hash multiply, fade result
    logic [31:0] bm_next [4];
    logic [16:0] fd_next [2];

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            logic [31:0] ar;
            ar = am_reg[c % 2];
            bm_next[c] = (by_reg[c / 2] ^ {ar[15:0], ar[31:16]}) * HASH_M2;
        end
        for (int a = 0; a < 2; a++) begin
            logic [35:0] sp;
            sp = t3_reg[a] * q_reg[a][19:0];
            fd_next[a] = sp[32:16];
        end
    end

    logic [31:0] bm_reg [4];
    logic [31:0] am3_reg [2];
    logic [16:0] fd_reg [3:9][2];

    // ---------------- stage 4: third hash multiply
    logic [31:0] af_next [4];

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            af_next[c] = (am3_reg[c % 2] ^ {bm_reg[c][15:0], bm_reg[c][31:16]}) * HASH_M3;
        end
    end

    logic [31:0] af_reg [4];

    // ---------------- stage 5: angle to gradient through the sine table
    logic signed [16:0] gx_next [4];
    logic signed [16:0] gy_next [4];

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            logic [ANGLE_BITS-1:0] idx;
            logic [ANGLE_BITS-3:0] r;
            logic [ANGLE_BITS-2:0] rc;
            logic signed [16:0]    sr;
            logic signed [16:0]    sc;
            idx = af_reg[c][31:32-ANGLE_BITS];
            r   = idx[ANGLE_BITS-3:0];
            rc  = (ANGLE_BITS-1)'(ROM_N) - {1'b0, r};
            sr  = $signed({1'b0, SIN_ROM[{1'b0, r}]});
            sc  = $signed({1'b0, SIN_ROM[rc]});
            case (idx[ANGLE_BITS-1:ANGLE_BITS-2])
                2'd0: begin gx_next[c] = sc;  gy_next[c] = sr;  end
                2'd1: begin gx_next[c] = -sr; gy_next[c] = sc;  end
                2'd2: begin gx_next[c] = -sc; gy_next[c] = -sr; end
                default: begin gx_next[c] = sr; gy_next[c] = -sc; end
            endcase
        end
    end

    logic signed [16:0] gx_reg [4];
    logic signed [16:0] gy_reg [4];

    // ---------------- stage 6: dot product terms
    logic signed [33:0] px_next [4];
    logic signed [33:0] py_next [4];

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            logic signed [16:0] dx;
            logic signed [16:0] dy;
            dx = $signed({((c % 2) == 1), fr_reg[5][0]});
            dy = $signed({((c / 2) == 1), fr_reg[5][1]});
            px_next[c] = dx * gx_reg[c];
            py_next[c] = dy * gy_reg[c];
        end
    end

    logic signed [33:0] px_reg [4];
    logic signed [33:0] py_reg [4];

    // ---------------- stage 7: dot sums, floor to Q15
    logic signed [18:0] n_next [4];

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            logic signed [34:0] sm;
            sm = 35'(px_reg[c]) + 35'(py_reg[c]);
            n_next[c] = sm[34:16];
        end
    end

    logic signed [18:0] n_reg [4];

    // ---------------- stage 8: row blend products
    logic signed [37:0] bp_next [2];

    always_comb begin
        for (int r = 0; r < 2; r++) begin
            logic signed [19:0] d;
            d = 20'(n_reg[2*r+1]) - 20'(n_reg[2*r]);
            bp_next[r] = d * $signed({1'b0, fd_reg[7][0]});
        end
    end

    logic signed [37:0] bp_reg [2];
    logic signed [18:0] n8_reg [2];

    // ---------------- stage 9: row values
    logic signed [21:0] row_next [2];

    always_comb begin
        for (int r = 0; r < 2; r++) begin
            row_next[r] = 22'(n8_reg[r]) + bp_reg[r][37:16];
        end
    end

    logic signed [21:0] row_reg [2];

    // ---------------- stage 10: column blend product
    logic signed [22:0] dv;
    logic signed [40:0] vp_next;

    always_comb begin
        dv      = 23'(row_reg[1]) - 23'(row_reg[0]);
        vp_next = dv * $signed({1'b0, fd_reg[9][1]});
    end

    logic signed [40:0] vp_reg;
    logic signed [21:0] row10_reg;

    // ---------------- stage 11: noise value
    logic signed [24:0] v_next;

    assign v_next = 25'(row10_reg) + vp_reg[40:16];

    logic signed [24:0] v_reg;

    // ---------------- stage 12: saturate and gray map
    logic signed [15:0] sat_next;
    logic [7:0]         gray_next;

    always_comb begin
        logic signed [25:0] vo;
        logic signed [33:0] g;
        if (v_reg > 25'sd32767) begin
            sat_next = 16'sh7fff;
        end else if (v_reg < -25'sd32768) begin
            sat_next = 16'sh8000;
        end else begin
            sat_next = v_reg[15:0];
        end
        vo = 26'(v_reg) + 26'sd32768;
        g  = (34'(vo) <<< 8) - 34'(vo);
        if (g < 0) begin
            gray_next = '0;
        end else if (g[33:16] > 18'd255) begin
            gray_next = 8'd255;
        end else begin
            gray_next = g[23:16];
        end
    end

    logic [15:0] noise_reg;
    logic [7:0]  gray_reg;
    logic        oor_out_reg;

    // pipeline payload registers
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int a = 0; a < 2; a++) begin
                pos_reg[a]    <= pos_next[a];
                t2_reg[a]     <= t2_next[a];
                p_reg[a]      <= p_next[a];
                fr_reg[1][a]  <= in_f[a];
                am_reg[a]     <= am_next[a];
                by_reg[a]     <= pos_reg[1][a];
                t3_reg[a]     <= t3_next[a];
                q_reg[a]      <= q_next[a];
                am3_reg[a]    <= am_reg[a];
                fd_reg[3][a]  <= fd_next[a];
                bp_reg[a]     <= bp_next[a];
                n8_reg[a]     <= n_reg[2*a];
                row_reg[a]    <= row_next[a];
            end
            for (int s = 2; s <= 5; s++) begin
                fr_reg[s] <= fr_reg[s-1];
            end
            for (int s = 4; s <= 9; s++) begin
                fd_reg[s] <= fd_reg[s-1];
            end
            oor_reg[1] <= oor_next;
            for (int s = 2; s <= 11; s++) begin
                oor_reg[s] <= oor_reg[s-1];
            end
            for (int c = 0; c < 4; c++) begin
                bm_reg[c] <= bm_next[c];
                af_reg[c] <= af_next[c];
                gx_reg[c] <= gx_next[c];
                gy_reg[c] <= gy_next[c];
                px_reg[c] <= px_next[c];
                py_reg[c] <= py_next[c];
                n_reg[c]  <= n_next[c];
            end
            vp_reg      <= vp_next;
            row10_reg   <= row_reg[0];
            v_reg       <= v_next;
            noise_reg   <= sat_next;
            gray_reg    <= gray_next;
            oor_out_reg <= oor_reg[11];
        end
    end

    assign m_axis_tdata = {7'd0, oor_out_reg, gray_reg, noise_reg};

endmodule
